/* rtl/core/ccc_pkg.sv */
// Shared constants and types for the connected component counter core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ccc_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_ARCS     = 8192;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = $clog2(MAX_ARCS);
    localparam int CW = VW + 1;
    localparam int NW = AW + 1;
    typedef logic [VW-1:0] vtx_t;
    typedef logic [NW-1:0] arc_ptr_t;
    typedef logic [CW-1:0] cnt_t;
endpackage
`default_nettype wire

/* rtl/core/connected_component_counter_core.sv */
// Connected component counter top level: edge loading, depth-first count walk,
// output register. Depends on ccc_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Edge beats are taken one at a time while loading. A stored edge links its two
// arcs in states ARC1, ARC2 and ARC3 after the beat, during which s_tready is low;
// a dropped edge or a bare beat stores no arcs. The beat with tlast starts a
// count over single-port memories: each arc is scanned in ARC_RD, ARC_VIS and
// ARC_CHK, and the target it pushes is popped in POP, POP_RD and VIS_CHK. After
// reset and after each result a clearing pass over all 1024 vertices resets
// the list heads and visited map. No beat is taken during the count, while the
// result waits, or while clearing.
module connected_component_counter_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [10:0] cfg_wr_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // vertex_a[9:0], vertex_b[19:10], has_edge[20]
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // component_count[10:0], edge_dropped[11]
);
    typedef enum logic [3:0] {
        CLEAR, IDLE, ARC1, ARC2, ARC3, CNT_RD, CNT_CHK, POP, POP_RD, VIS_CHK,
        ARC_RD, ARC_VIS, ARC_CHK, DONE
    } state_t;

    state_t state_reg;
    logic [ccc_pkg::CW-1:0] vcount_reg;
    logic [ccc_pkg::VW-1:0] clr_reg;
    logic [ccc_pkg::CW-1:0] v_reg;
    logic [ccc_pkg::NW-1:0] arc_cnt_reg;
    logic [ccc_pkg::NW-1:0] sp_reg;
    logic [ccc_pkg::NW-1:0] arc_reg;
    logic [ccc_pkg::VW-1:0] a_reg, b_reg, cur_reg;
    logic [ccc_pkg::CW-1:0] total_reg;
    logic drop_reg, last_reg;

    logic [ccc_pkg::NW-1:0] head_mem [ccc_pkg::MAX_VERTICES];
    logic                   vis_mem  [ccc_pkg::MAX_VERTICES];
    logic [ccc_pkg::VW-1:0] tgt_mem  [ccc_pkg::MAX_ARCS];
    logic [ccc_pkg::NW-1:0] nxt_mem  [ccc_pkg::MAX_ARCS];
    logic [ccc_pkg::VW-1:0] stk_mem  [ccc_pkg::MAX_ARCS];

    logic [ccc_pkg::NW-1:0] head_q;
    logic                   vis_q;
    logic [ccc_pkg::VW-1:0] tgt_q, stk_q;
    logic [ccc_pkg::NW-1:0] nxt_q;

    logic [ccc_pkg::CW-1:0] live_n;
    assign live_n = (vcount_reg > ccc_pkg::CW'(ccc_pkg::MAX_VERTICES)) ?
                    ccc_pkg::CW'(ccc_pkg::MAX_VERTICES) : vcount_reg;

    logic [ccc_pkg::VW-1:0] in_a, in_b;
    logic in_e, take;
    assign in_a = s_tdata[9:0];
    assign in_b = s_tdata[19:10];
    assign in_e = s_tdata[20];
    assign s_tready = (state_reg == IDLE);
    assign take = s_tvalid && s_tready;

    logic edge_ok;
    assign edge_ok = ({1'b0, in_a} < live_n) && ({1'b0, in_b} < live_n) &&
                     (arc_cnt_reg <= ccc_pkg::NW'(ccc_pkg::MAX_ARCS - 2));

    logic push_ok;
    assign push_ok = ({1'b0, tgt_q} < live_n) && !vis_q &&
                     (sp_reg < ccc_pkg::NW'(ccc_pkg::MAX_ARCS));

    // Memory address and write controls.
    logic [ccc_pkg::VW-1:0] h_addr, vis_addr;
    logic h_we, vis_we, vis_wd;
    logic [ccc_pkg::NW-1:0] h_wd;
    logic [ccc_pkg::AW-1:0] arc_addr, stk_addr;
    logic arc_we, stk_we;
    logic [ccc_pkg::VW-1:0] tgt_wd, stk_wd;
    logic [ccc_pkg::NW-1:0] nxt_wd;

    always_comb begin
        h_addr = cur_reg; h_we = 1'b0; h_wd = head_q;
        vis_addr = cur_reg; vis_we = 1'b0; vis_wd = 1'b1;
        arc_addr = arc_reg[ccc_pkg::AW-1:0]; arc_we = 1'b0; tgt_wd = b_reg; nxt_wd = head_q;
        stk_addr = sp_reg[ccc_pkg::AW-1:0]; stk_we = 1'b0; stk_wd = tgt_q;
        unique case (state_reg)
            CLEAR: begin
                h_addr = clr_reg; h_we = 1'b1; h_wd = ccc_pkg::NW'(ccc_pkg::MAX_ARCS);
                vis_addr = clr_reg; vis_we = 1'b1; vis_wd = 1'b0;
            end
            IDLE: begin
                h_addr = in_a;
            end
            ARC1: begin
                h_addr = a_reg; h_we = 1'b1; h_wd = arc_cnt_reg;
                arc_addr = arc_cnt_reg[ccc_pkg::AW-1:0]; arc_we = 1'b1;
                tgt_wd = b_reg; nxt_wd = head_q;
            end
            ARC2: begin
                h_addr = b_reg;
            end
            ARC3: begin
                h_addr = b_reg; h_we = 1'b1; h_wd = arc_cnt_reg + 1'b1;
                arc_addr = arc_cnt_reg[ccc_pkg::AW-1:0] + 1'b1; arc_we = 1'b1;
                tgt_wd = a_reg; nxt_wd = head_q;
            end
            CNT_RD: begin
                vis_addr = v_reg[ccc_pkg::VW-1:0];
            end
            CNT_CHK: begin
                stk_addr = '0; stk_we = !vis_q; stk_wd = v_reg[ccc_pkg::VW-1:0];
            end
            POP: begin
                stk_addr = sp_reg[ccc_pkg::AW-1:0] - 1'b1;
            end
            POP_RD: begin
                vis_addr = stk_q; h_addr = stk_q;
            end
            VIS_CHK: begin
                vis_we = !vis_q;
            end
            ARC_VIS: begin
                vis_addr = tgt_q;
            end
            ARC_CHK: begin
                stk_we = push_ok;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (arc_we) begin
            tgt_mem[arc_addr] <= tgt_wd;
            nxt_mem[arc_addr] <= nxt_wd;
        end
        tgt_q <= tgt_mem[arc_addr];
        nxt_q <= nxt_mem[arc_addr];
        if (h_we) head_mem[h_addr] <= h_wd;
        head_q <= head_mem[h_addr];
        if (vis_we) vis_mem[vis_addr] <= vis_wd;
        vis_q <= vis_mem[vis_addr];
        if (stk_we) stk_mem[stk_addr] <= stk_wd;
        stk_q <= stk_mem[stk_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLEAR; clr_reg <= '0; vcount_reg <= ccc_pkg::CW'(1);
            arc_cnt_reg <= '0; drop_reg <= 1'b0; m_tvalid <= 1'b0; sp_reg <= '0;
        end else begin
            if (cfg_wr_en) vcount_reg <= cfg_wr_data;
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            unique case (state_reg)
                CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ccc_pkg::VW'(ccc_pkg::MAX_VERTICES - 1)) state_reg <= IDLE;
                end
                IDLE: if (take) begin
                    a_reg <= in_a; b_reg <= in_b; last_reg <= s_tlast;
                    v_reg <= '0; total_reg <= '0;
                    if (in_e && !edge_ok) drop_reg <= 1'b1;
                    if (in_e && edge_ok) begin
                        state_reg <= ARC1;
                    end else if (s_tlast) begin
                        state_reg <= CNT_RD;
                    end
                end
                ARC1: state_reg <= ARC2;
                ARC2: state_reg <= ARC3;
                ARC3: begin
                    arc_cnt_reg <= arc_cnt_reg + 2'd2;
                    state_reg <= last_reg ? CNT_RD : IDLE;
                end
                CNT_RD: state_reg <= (v_reg >= live_n) ? DONE : CNT_CHK;
                CNT_CHK: begin
                    if (vis_q) begin
                        v_reg <= v_reg + 1'b1; state_reg <= CNT_RD;
                    end else begin
                        total_reg <= total_reg + 1'b1;
                        sp_reg <= ccc_pkg::NW'(1);
                        state_reg <= POP;
                    end
                end
                POP: begin
                    if (sp_reg == '0) begin
                        v_reg <= v_reg + 1'b1; state_reg <= CNT_RD;
                    end else begin
                        sp_reg <= sp_reg - 1'b1; state_reg <= POP_RD;
                    end
                end
                POP_RD: begin
                    cur_reg <= stk_q; state_reg <= VIS_CHK;
                end
                VIS_CHK: begin
                    if (vis_q) state_reg <= POP;
                    else begin
                        arc_reg <= head_q; state_reg <= ARC_RD;
                    end
                end
                ARC_RD: state_reg <= (arc_reg < arc_cnt_reg) ? ARC_VIS : POP;
                ARC_VIS: state_reg <= ARC_CHK;
                ARC_CHK: begin
                    if (push_ok) sp_reg <= sp_reg + 1'b1;
                    arc_reg <= nxt_q;
                    state_reg <= ARC_RD;
                end
                DONE: if (!m_tvalid) begin
                    m_tvalid <= 1'b1;
                    m_tdata <= {4'b0, drop_reg, total_reg};
                    drop_reg <= 1'b0; arc_cnt_reg <= '0; clr_reg <= '0;
                    state_reg <= CLEAR;
                end
                default: state_reg <= CLEAR;
            endcase
        end
    end
endmodule
`default_nettype wire
